// ----- rtl/core/grsi_pkg.sv -----
`timescale 1ns / 1ps
package grsi_pkg;
	localparam logic [1:0] OP_LOAD_POS = 2'd0;
	localparam logic [1:0] OP_LOAD_AMP = 2'd1;
	localparam logic [1:0] OP_QUERY    = 2'd2;
	localparam logic [1:0] OP_RESERVED = 2'd3;

	localparam logic [1:0] REG_SENSOR_COUNT = 2'd0;
	localparam logic [1:0] REG_GAUSS_SCALE  = 2'd1;
	localparam logic [1:0] REG_RADIUS_SQ    = 2'd2;
	localparam logic [1:0] REG_FILL_VALUE   = 2'd3;

	localparam int COORD_W = 20;
	localparam int AMP_W   = 24;
	localparam int WEIGHT_W = 16;
	localparam int D2_W    = 44;
	localparam int PROD_W  = 37;
	localparam int IDX_SHIFT = 25;
	localparam logic [63:0] EXP_STEP_Q32 = 64'd4261543596;

	typedef struct packed {
		logic [AMP_W-1:0] amplitude;
		logic             radius_hit;
		logic             hidden;
	} result_t;

	// Gaussian weight table entry, Q0.16, one step of exp(-1/128) per index.
	function automatic logic [WEIGHT_W-1:0] exp_entry(input int idx);
		logic [63:0]  acc;
		logic [127:0] p;
		logic [63:0]  e;
		acc = 64'd1 << 32;
		for (int i = 0; i < idx; i++) begin
			p = 128'(acc) * 128'(EXP_STEP_Q32) + (128'd1 << 31);
			acc = p[95:32];
		end
		e = (acc + 64'd32768) >> 16;
		exp_entry = (e > 64'd65535) ? 16'hFFFF : e[15:0];
	endfunction
endpackage

// ----- rtl/core/grsi_ram.sv -----
`timescale 1ns / 1ps
module grsi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/core/grsi_exp_rom.sv -----
`timescale 1ns / 1ps
module grsi_exp_rom #(
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	output logic [15:0]              data
);
	import grsi_pkg::*;
	logic [WEIGHT_W-1:0] rom [DEPTH];

	// Table is built at elaboration: each entry is its own constant.
	for (genvar g = 0; g < DEPTH; g++) begin : g_rom
		assign rom[g] = exp_entry(g);
	end

	always_ff @(posedge clk) begin
		data <= rom[addr];
	end
endmodule

// ----- rtl/core/grsi_divider.sv -----
`timescale 1ns / 1ps
module grsi_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] div_q;
	logic [64:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, div_q};

	// Restoring division, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule

// ----- rtl/core/gaussian_rbf_sensor_interpolator.sv -----
`timescale 1ns / 1ps
// A query for n active sensors makes one pass over the sensor memories
// (one entry per cycle through a six-stage distance / weight / accumulate
// pipe) and, when the weight sum is nonzero, a bit-serial divide for the
// weighted mean. One item is in flight at a time.
// Async active-low reset restores the registers to their defaults and empties
// the output register; the sensor memories keep undefined contents until written.
module gaussian_rbf_sensor_interpolator #(
	parameter int MAX_SENSORS = 64,
	parameter int EXP_TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [5:0]  sensor_index,
	input  logic signed [19:0] pos_x,
	input  logic signed [19:0] pos_y,
	input  logic signed [19:0] pos_z,
	input  logic signed [23:0] new_amplitude,
	input  logic        vertex_visible,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [23:0] amplitude,
	output logic        radius_hit,
	output logic        hidden
);
	import grsi_pkg::*;

	localparam int AW = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
	localparam int CW = AW + 1;
	localparam int TW = $clog2(EXP_TABLE_DEPTH);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_WALK = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd5;

	// ---------------- configuration registers
	logic [6:0]  sensor_count_q;
	logic [31:0] gauss_scale_q;
	logic [41:0] radius_sq_q;
	logic [23:0] fill_value_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_count_q <= 7'd64;
			gauss_scale_q  <= 32'd65536;
			radius_sq_q    <= 42'd400000000;
			fill_value_q   <= '0;
		end else if (cfg_wr && paddr[2:0] == 3'd0) begin
			case (paddr[4:3])
				REG_SENSOR_COUNT: sensor_count_q <= pwdata[6:0];
				REG_GAUSS_SCALE:  gauss_scale_q  <= pwdata[31:0];
				REG_RADIUS_SQ:    radius_sq_q    <= pwdata[41:0];
				REG_FILL_VALUE:   fill_value_q   <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (paddr[4:3])
			REG_SENSOR_COUNT: prdata = 64'(sensor_count_q);
			REG_GAUSS_SCALE:  prdata = 64'(gauss_scale_q);
			REG_RADIUS_SQ:    prdata = 64'(radius_sq_q);
			REG_FILL_VALUE:   prdata = 64'(fill_value_q);
			default: prdata = '0;
		endcase
	end

	// ---------------- control
	logic [2:0]  state_q;
	logic        accept;
	logic        is_load;
	logic [CW-1:0] n_active;
	logic [CW-1:0] rd_cnt_q;
	logic [3:0]  drain_q;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	// sensor_count saturates at the sensor memory depth (MAX_SENSORS)
	assign n_active = (32'(sensor_count_q) > MAX_SENSORS) ? CW'(MAX_SENSORS)
	                                                      : CW'(sensor_count_q);
	assign is_load = 32'(sensor_index) < MAX_SENSORS;

	// ---------------- sensor memories: write on load, read during the walk
	logic we_pos, we_amp;
	logic [AW-1:0] waddr, raddr;
	logic [19:0] mx, my, mz;
	logic [23:0] ma;

	assign we_pos = accept && opcode == OP_LOAD_POS && is_load;
	assign we_amp = accept && opcode == OP_LOAD_AMP && is_load;
	assign waddr  = AW'(sensor_index);
	assign raddr  = rd_cnt_q[AW-1:0];

	grsi_ram #(.WIDTH(20), .DEPTH(MAX_SENSORS)) u_ram_x (.clk, .we(we_pos), .waddr,
		.wdata(pos_x), .raddr, .rdata(mx));
	grsi_ram #(.WIDTH(20), .DEPTH(MAX_SENSORS)) u_ram_y (.clk, .we(we_pos), .waddr,
		.wdata(pos_y), .raddr, .rdata(my));
	grsi_ram #(.WIDTH(20), .DEPTH(MAX_SENSORS)) u_ram_z (.clk, .we(we_pos), .waddr,
		.wdata(pos_z), .raddr, .rdata(mz));
	grsi_ram #(.WIDTH(24), .DEPTH(MAX_SENSORS)) u_ram_a (.clk, .we(we_amp), .waddr,
		.wdata(new_amplitude), .raddr, .rdata(ma));

	// query vertex held for the whole walk
	logic signed [19:0] vx_q, vy_q, vz_q;
	logic vis_q;

	// ---------------- walk pipeline
	// s1: memory read data valid. s2: squares. s3: d2 sum. s4: two partial
	// products of d2*scale and range. s5: table read. s6: accumulate.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [20:0] dx, dy, dz;
	logic [20:0] ax, ay, az;
	logic [41:0] sx_s2, sy_s2, sz_s2;
	logic [23:0] a_s2, a_s3, a_s4, a_s5;
	logic [D2_W-1:0] d2_s3;
	logic [53:0] plo_s4, phi_s4;
	logic [75:0] prod;
	logic hit_s4, ok_s5, hit_s5;
	logic tbl_ok;
	logic [TW-1:0] tbl_idx;
	logic [15:0] w_rom;
	logic any_q;
	logic signed [47:0] num_q;
	logic [CW+15:0] den_q;

	assign dx = 21'(vx_q) - 21'(signed'(mx));
	assign dy = 21'(vy_q) - 21'(signed'(my));
	assign dz = 21'(vz_q) - 21'(signed'(mz));
	assign ax = dx[20] ? 21'(-dx) : 21'(dx);
	assign ay = dy[20] ? 21'(-dy) : 21'(dy);
	assign az = dz[20] ? 21'(-dz) : 21'(dz);
	// join the partial products and index the table in the same cycle
	assign prod    = (76'(phi_s4) << 22) + 76'(plo_s4);
	assign tbl_ok  = (prod >> IDX_SHIFT) < 76'(EXP_TABLE_DEPTH);
	assign tbl_idx = TW'(prod >> IDX_SHIFT);

	always_ff @(posedge clk) begin
		sx_s2 <= 42'(ax) * 42'(ax);
		sy_s2 <= 42'(ay) * 42'(ay);
		sz_s2 <= 42'(az) * 42'(az);
		a_s2  <= ma;
		d2_s3 <= D2_W'(sx_s2) + D2_W'(sy_s2) + D2_W'(sz_s2);
		a_s3  <= a_s2;
		hit_s4 <= d2_s3 <= D2_W'(radius_sq_q);
		plo_s4 <= 54'(d2_s3[21:0]) * 54'(gauss_scale_q);
		phi_s4 <= 54'(d2_s3[43:22]) * 54'(gauss_scale_q);
		a_s4   <= a_s3;
		hit_s5 <= hit_s4;
		ok_s5  <= tbl_ok;
		a_s5   <= a_s4;
	end

	grsi_exp_rom #(.DEPTH(EXP_TABLE_DEPTH)) u_rom (.clk, .addr(tbl_idx), .data(w_rom));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_WALK) && (rd_cnt_q < n_active);
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
		end
	end

	// ---------------- divide and result
	logic [47:0] mag;
	logic div_start, div_done;
	logic [63:0] quot;
	logic res_v_q;
	result_t res_q;
	logic neg_q;

	assign mag = num_q[47] ? 48'(-num_q) : 48'(num_q);
	assign div_start = (state_q == ST_DRAIN) && drain_q == 4'd0 && any_q && den_q != '0;

	grsi_divider u_div (.clk, .arst_n, .start(div_start),
		.dividend(64'({mag, 1'b0}) + 64'(den_q)),
		.divisor(64'({den_q, 1'b0})), .done(div_done), .quotient(quot));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_cnt_q <= '0;
			drain_q  <= '0;
			res_v_q  <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!res_v_q || !out_stall)) res_v_q <= 1'b1;
			else if (res_v_q && !out_stall) res_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (accept && opcode == OP_QUERY) begin
					state_q  <= ST_WALK;
					rd_cnt_q <= '0;
				end
				ST_WALK: begin
					if (rd_cnt_q >= n_active) begin
						state_q <= ST_DRAIN;
						drain_q <= 4'd6;
					end else rd_cnt_q <= rd_cnt_q + CW'(1);
				end
				ST_DRAIN: begin
					if (drain_q != 4'd0) drain_q <= drain_q - 4'd1;
					else if (div_start) state_q <= ST_DIV;
					else state_q <= ST_OUT;
				end
				ST_DIV: if (div_done) state_q <= ST_OUT;
				ST_OUT: if (!res_v_q || !out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vx_q  <= pos_x;
			vy_q  <= pos_y;
			vz_q  <= pos_z;
			vis_q <= vertex_visible;
			any_q <= 1'b0;
			num_q <= '0;
			den_q <= '0;
			neg_q <= 1'b0;
		end else if (v_s5 && hit_s5) begin
			// accumulate; only sensors within the radius count, and distances beyond the table add zero weight
			any_q <= 1'b1;
			num_q <= num_q + 48'(signed'({1'b0, ok_s5 ? w_rom : 16'd0}) * signed'(a_s5));
			den_q <= den_q + (CW+16)'(ok_s5 ? w_rom : 16'd0);
		end
		if (div_start) neg_q <= num_q[47];
		if (state_q == ST_OUT && (!res_v_q || !out_stall)) begin
			res_q.radius_hit <= any_q;
			res_q.hidden     <= !vis_q;
			if (!vis_q) res_q.amplitude <= '0;
			else if (!any_q) res_q.amplitude <= fill_value_q;
			else if (den_q == '0) res_q.amplitude <= '0;
			else res_q.amplitude <= neg_q ? 24'(-quot[23:0]) : quot[23:0];
		end
	end

	assign out_valid  = res_v_q;
	assign amplitude  = res_q.amplitude;
	assign radius_hit = res_q.radius_hit;
	assign hidden     = res_q.hidden;

	a_stall_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !in_stall) else $error("stall while idle");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> rd_cnt_q <= n_active) else $error("walk overran");
endmodule
